// ----- hdl/ogm_pkg.sv -----
package ogm_pkg;

  // Channel and configuration widths.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  // Occupancy value of a cell that has never been observed.
  localparam logic [7:0] CELL_UNKNOWN = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE  = 3'd4;

  // Item actions carried on in_tuser.
  typedef enum logic [1:0] {
    ACT_DIFF    = 2'd0,
    ACT_MERGE   = 2'd1,
    ACT_BOX_CLR = 2'd2
  } act_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_ADDR  = 2'd2,
    ST_EVAL  = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic item_load;
    logic eval;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/ogm_ram.sv -----
module ogm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/ogm_ctrl.sv -----
module ogm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ogm_pkg::dp_stat_t  stat,
  output ogm_pkg::ctrl_cmd_t cmd
);

  ogm_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ogm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.clr_step  = 1'b0;
    cmd.item_load = 1'b0;
    cmd.eval      = 1'b0;
    case (state_r)
      ogm_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ogm_pkg::ST_IDLE;
        end
      end
      ogm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.item_load = 1'b1;
          state_nxt     = ogm_pkg::ST_ADDR;
        end
      end
      ogm_pkg::ST_ADDR: begin
        state_nxt = ogm_pkg::ST_EVAL;
      end
      ogm_pkg::ST_EVAL: begin
        if (stat.out_free) begin
          cmd.eval  = 1'b1;
          state_nxt = ogm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ogm_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/ogm_dp.sv -----
module ogm_dp #(
  parameter int MAX_SIDE = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ogm_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [ogm_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ogm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_wen,
  input  logic [ogm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ogm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  ogm_pkg::ctrl_cmd_t                  cmd,
  output ogm_pkg::dp_stat_t                   stat
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = (SW > 10) ? SW : 10;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] SIDE_A    = AW'(MAX_SIDE);
  localparam logic [CW-1:0] SIDE_C    = CW'(MAX_SIDE);

  // Configuration registers.
  logic [8:0] map_width_r, map_height_r;
  logic [9:0] offset_x_r, offset_y_r;
  logic       overwrite_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
      overwrite_r  <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index)
        ogm_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_wdata[8:0];
        ogm_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_wdata[8:0];
        ogm_pkg::REG_OFFSET_X:   offset_x_r   <= cfg_wdata;
        ogm_pkg::REG_OFFSET_Y:   offset_y_r   <= cfg_wdata;
        ogm_pkg::REG_OVERWRITE:  overwrite_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Item register, loaded on the input transfer.
  logic [1:0] act_r;
  logic [7:0] col_r, row_r, val_r;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      act_r <= in_tuser;
      col_r <= in_tdata[7:0];
      row_r <= in_tdata[15:8];
      val_r <= in_tdata[23:16];
    end
  end

  logic is_diff, is_merge, is_box_clr;
  assign is_diff    = (act_r == ogm_pkg::ACT_DIFF);
  assign is_merge   = (act_r == ogm_pkg::ACT_MERGE);
  assign is_box_clr = (act_r == ogm_pkg::ACT_BOX_CLR);

  // Target cell: merge items are shifted by the offsets.
  logic signed [10:0] tc, tr;
  always_comb begin
    tc = signed'({3'b000, col_r});
    tr = signed'({3'b000, row_r});
    if (is_merge) begin
      tc = tc + signed'({offset_x_r[9], offset_x_r});
      tr = tr + signed'({offset_y_r[9], offset_y_r});
    end
  end

  // Grid size in use, limited to the physical side.
  logic [CW-1:0] w_ext, h_ext, w_lim, h_lim;
  assign w_ext = CW'(map_width_r);
  assign h_ext = CW'(map_height_r);
  assign w_lim = (w_ext > SIDE_C) ? SIDE_C : w_ext;
  assign h_lim = (h_ext > SIDE_C) ? SIDE_C : h_ext;

  logic inb;
  assign inb = (is_diff || is_merge) && !tc[10] && !tr[10] &&
               (CW'(tc[9:0]) < w_lim) && (CW'(tr[9:0]) < h_lim);

  logic [AW-1:0] cell_addr;
  assign cell_addr = AW'(tr[9:0]) * SIDE_A + AW'(tc[9:0]);

  // The bounds result is held for the evaluation cycle.
  logic inb_r;
  always_ff @(posedge clk) begin
    inb_r <= inb;
  end

  // Clearing pass after reset.
  logic [AW-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end
  assign stat.clr_last = (clr_cnt_r == LAST_ADDR);

  // Merge decision on the stored cell.
  logic [7:0] cur;
  logic       known, differs, wr_cond, changed;
  assign known   = (val_r != ogm_pkg::CELL_UNKNOWN);
  assign differs = (cur != val_r);
  assign wr_cond = is_merge && inb_r &&
                   ((cur == ogm_pkg::CELL_UNKNOWN) || (overwrite_r && known && differs));
  assign changed = is_diff && inb_r && known && differs;

  // Grid memory.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  assign ram_we    = cmd.clr_step || (cmd.eval && wr_cond);
  assign ram_addr  = cmd.clr_step ? clr_cnt_r : cell_addr;
  assign ram_wdata = cmd.clr_step ? ogm_pkg::CELL_UNKNOWN : val_r;

  ogm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (cur)
  );

  // Change box.
  logic       box_seen_r, box_seen_nxt;
  logic [7:0] box_l_r, box_t_r, box_rt_r, box_b_r;
  logic [7:0] box_l_nxt, box_t_nxt, box_rt_nxt, box_b_nxt;

  always_comb begin
    box_seen_nxt = box_seen_r;
    box_l_nxt    = box_l_r;
    box_t_nxt    = box_t_r;
    box_rt_nxt   = box_rt_r;
    box_b_nxt    = box_b_r;
    if (is_box_clr) begin
      box_seen_nxt = 1'b0;
      box_l_nxt    = '0;
      box_t_nxt    = '0;
      box_rt_nxt   = '0;
      box_b_nxt    = '0;
    end else if (changed) begin
      box_seen_nxt = 1'b1;
      if (!box_seen_r) begin
        box_l_nxt  = col_r;
        box_rt_nxt = col_r;
        box_t_nxt  = row_r;
        box_b_nxt  = row_r;
      end else begin
        if (col_r < box_l_r)  box_l_nxt  = col_r;
        if (col_r > box_rt_r) box_rt_nxt = col_r;
        if (row_r < box_t_r)  box_t_nxt  = row_r;
        if (row_r > box_b_r)  box_b_nxt  = row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_seen_r <= 1'b0;
      box_l_r    <= '0;
      box_t_r    <= '0;
      box_rt_r   <= '0;
      box_b_r    <= '0;
    end else if (cmd.eval) begin
      box_seen_r <= box_seen_nxt;
      box_l_r    <= box_l_nxt;
      box_t_r    <= box_t_nxt;
      box_rt_r   <= box_rt_nxt;
      box_b_r    <= box_b_nxt;
    end
  end

  // Output register; it frees up in the cycle its transfer completes.
  logic       out_valid_r;
  logic [7:0] stored;
  assign stored = !inb_r ? ogm_pkg::CELL_UNKNOWN : (wr_cond ? val_r : cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.eval) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [ogm_pkg::OUT_TDATA_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_data_r <= {5'b00000, box_b_nxt, box_rt_nxt, box_t_nxt, box_l_nxt,
                     box_seen_nxt, stored, wr_cond, inb_r};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

// ----- hdl/occupancy_grid_greedy_merge.sv -----
// Occupancy grid greedy merge.
// Holds a MAX_SIDE x MAX_SIDE grid of unsigned 8-bit occupancy cells. Each input
// transfer carries one item: a diff against a local map cell, a merge of a
// shifted tile cell, or a reset of the change box. Each item gives exactly one
// result transfer with the bounds flag, write flag, cell value and change box.
// Configuration is written through a plain write port; the user must do so only
// while the block is idle, which the block itself does not enforce. An item goes
// through accept, memory read, and evaluate and write back on the single grid
// memory port; a new item is accepted only once the last one has been evaluated.
// Reset: every register but the item, bounds and output data registers returns
// to its reset value, and the grid memory is swept to unknown one cell a cycle
// over all MAX_SIDE * MAX_SIDE cells (65536 by default); in_tready stays low in it.
// Stalls: the result waits in an output register. The next item is accepted
// while it waits; that item holds in its evaluate step until the pending
// result has been transferred.
module occupancy_grid_greedy_merge #(
  parameter int MAX_SIDE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // col[7:0], row[15:8], cell_value[23:16]
  input  logic [ogm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ogm_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // in_bounds[0], written[1], stored_value[9:2], box_valid[10],
  // box_left[18:11], box_top[26:19], box_right[34:27], box_bottom[42:35]
  output logic [ogm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wen,
  input  logic [ogm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ogm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ogm_pkg::ctrl_cmd_t cmd;
  ogm_pkg::dp_stat_t  stat;

  ogm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ogm_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- hdl/ogm_checker.sv -----
module ogm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ogm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // No result and no input transfer right after reset: the sweep runs first.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("output valid or input ready right after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A write can only happen to a cell inside the grid.
  a_wr_inb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] || !out_tdata[1]))
    else $error("write reported outside the grid");

  // Outside the grid the value reads as unknown.
  a_oob_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[9:2] == ogm_pkg::CELL_UNKNOWN)
    else $error("value outside the grid is not unknown");

  // An empty change box reads as all zero.
  a_box_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[10] |-> out_tdata[42:11] == 32'd0)
    else $error("empty change box is not zero");

endmodule

bind occupancy_grid_greedy_merge ogm_checker u_ogm_checker (.*);
